### hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/awl_pkg.sv
package awl_pkg;

  // window and field widths
  localparam int WINDOW = 8;
  localparam int ADC_W  = 10;
  localparam int MM_W   = 13;
  localparam int MM_MAX = (2 ** MM_W) - 1;
  localparam int NPTS   = 4;
  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W  = ADC_W + IDX_W;

  // stream and config port widths
  localparam int S_DATA_W   = 16;
  localparam int M_DATA_W   = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = MM_W;

  // interpolation arithmetic
  localparam int DIFF_W    = ADC_W + 1;
  localparam int DD_W      = MM_W + 1;
  localparam int PROD_W    = DIFF_W + DD_W;
  localparam int Q_W       = MM_W + 1;
  localparam int DIV_STEPS = Q_W / 2;
  localparam int DCNT_W    = $clog2(DIV_STEPS);
  localparam int VAL_W     = Q_W + 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADC_POINT_0      = 3'd0,
    REG_ADC_POINT_1      = 3'd1,
    REG_ADC_POINT_2      = 3'd2,
    REG_ADC_POINT_3      = 3'd3,
    REG_DISTANCE_POINT_0 = 3'd4,
    REG_DISTANCE_POINT_1 = 3'd5,
    REG_DISTANCE_POINT_2 = 3'd6,
    REG_DISTANCE_POINT_3 = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [NPTS-1:0][ADC_W-1:0] adc_pt;
    logic [NPTS-1:0][MM_W-1:0]  mm_pt;
  } cfg_t;

  // microcode fields
  typedef enum logic [2:0] {
    OP_LOAD,
    OP_ACC,
    OP_MEAN,
    OP_SETUP,
    OP_MUL,
    OP_DIVINIT,
    OP_DIV,
    OP_FINISH
  } op_e;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_INPUT,
    HOLD_OUTPUT
  } hold_e;

  typedef enum logic [2:0] {
    BR_NONE,
    BR_ALWAYS,
    BR_SUM_MORE,
    BR_SKIP,
    BR_DIV_MORE
  } br_e;

  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_LOAD    = 3'd0;
  localparam step_t ST_ACC     = 3'd1;
  localparam step_t ST_MEAN    = 3'd2;
  localparam step_t ST_SETUP   = 3'd3;
  localparam step_t ST_MUL     = 3'd4;
  localparam step_t ST_DIVINIT = 3'd5;
  localparam step_t ST_DIV     = 3'd6;
  localparam step_t ST_FINISH  = 3'd7;

  typedef struct packed {
    op_e   op;
    hold_e hold;
    br_e   br;
    step_t target;
  } uword_t;

  // sequencer to datapath
  typedef struct packed {
    op_e  op;
    logic fire;
  } dp_ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic sum_more;
    logic div_more;
    logic seg_skip;
    logic out_busy;
  } dp_status_t;

  // control store
  function automatic uword_t ucode_rom(step_t s);
    uword_t w;
    unique case (s)
      ST_LOAD:    w = '{op: OP_LOAD,    hold: HOLD_INPUT,  br: BR_NONE,     target: ST_LOAD};
      ST_ACC:     w = '{op: OP_ACC,     hold: HOLD_NONE,   br: BR_SUM_MORE, target: ST_ACC};
      ST_MEAN:    w = '{op: OP_MEAN,    hold: HOLD_NONE,   br: BR_NONE,     target: ST_MEAN};
      ST_SETUP:   w = '{op: OP_SETUP,   hold: HOLD_NONE,   br: BR_SKIP,     target: ST_FINISH};
      ST_MUL:     w = '{op: OP_MUL,     hold: HOLD_NONE,   br: BR_NONE,     target: ST_MUL};
      ST_DIVINIT: w = '{op: OP_DIVINIT, hold: HOLD_NONE,   br: BR_NONE,     target: ST_DIVINIT};
      ST_DIV:     w = '{op: OP_DIV,     hold: HOLD_NONE,   br: BR_DIV_MORE, target: ST_DIV};
      ST_FINISH:  w = '{op: OP_FINISH,  hold: HOLD_OUTPUT, br: BR_ALWAYS,   target: ST_LOAD};
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/awl_regs.sv
module awl_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [awl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [awl_pkg::CFG_DATA_W-1:0] cfg_data,
  output awl_pkg::cfg_t                  cfg
);
  import awl_pkg::*;

  // always ready, writes never stall
  assign cfg_ready = 1'b1;

  // breakpoint registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.adc_pt[0] <= ADC_W'(600);
      cfg.adc_pt[1] <= ADC_W'(400);
      cfg.adc_pt[2] <= ADC_W'(250);
      cfg.adc_pt[3] <= ADC_W'(100);
      cfg.mm_pt[0]  <= MM_W'(100);
      cfg.mm_pt[1]  <= MM_W'(200);
      cfg.mm_pt[2]  <= MM_W'(400);
      cfg.mm_pt[3]  <= MM_W'(800);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ADC_POINT_0:      cfg.adc_pt[0] <= cfg_data[ADC_W-1:0];
        REG_ADC_POINT_1:      cfg.adc_pt[1] <= cfg_data[ADC_W-1:0];
        REG_ADC_POINT_2:      cfg.adc_pt[2] <= cfg_data[ADC_W-1:0];
        REG_ADC_POINT_3:      cfg.adc_pt[3] <= cfg_data[ADC_W-1:0];
        REG_DISTANCE_POINT_0: cfg.mm_pt[0]  <= cfg_data[MM_W-1:0];
        REG_DISTANCE_POINT_1: cfg.mm_pt[1]  <= cfg_data[MM_W-1:0];
        REG_DISTANCE_POINT_2: cfg.mm_pt[2]  <= cfg_data[MM_W-1:0];
        REG_DISTANCE_POINT_3: cfg.mm_pt[3]  <= cfg_data[MM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/awl_seq.sv
`include "assert_macros.svh"

module awl_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  awl_pkg::dp_status_t status,
  output awl_pkg::dp_ctrl_t   ctrl
);
  import awl_pkg::*;

  step_t  step;
  step_t  step_next;
  uword_t uw;
  logic   hold;
  logic   take;

  // fetch the control word for this step
  assign uw = ucode_rom(step);

  // stall conditions
  always_comb begin
    case (uw.hold)
      HOLD_NONE:   hold = 1'b0;
      HOLD_INPUT:  hold = !in_valid;
      HOLD_OUTPUT: hold = status.out_busy;
      default:     hold = 1'b0;
    endcase
  end

  // branch conditions
  always_comb begin
    case (uw.br)
      BR_NONE:     take = 1'b0;
      BR_ALWAYS:   take = 1'b1;
      BR_SUM_MORE: take = status.sum_more;
      BR_SKIP:     take = status.seg_skip;
      BR_DIV_MORE: take = status.div_more;
      default:     take = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    if (hold) begin
      step_next = step;
    end else if (take) begin
      step_next = uw.target;
    end else begin
      step_next = step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_LOAD;
    end else begin
      step <= step_next;
    end
  end

  assign in_ready  = (uw.op == OP_LOAD);
  assign ctrl.op   = uw.op;
  assign ctrl.fire = !hold;

  `ASSERT_NEXT(a_load_then_sum, clk, rst, in_valid && in_ready, step == ST_ACC, "transfer not followed by window sum")
  `ASSERT_IMPLIES(a_div_needs_segment, clk, rst, ctrl.fire && uw.op == OP_DIV, !status.seg_skip, "divide on an unusable segment")

endmodule

### hw/rtl/awl_dp.sv
`include "assert_macros.svh"

module awl_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  awl_pkg::dp_ctrl_t         ctrl,
  input  awl_pkg::cfg_t             cfg,
  input  logic [awl_pkg::ADC_W-1:0] sample,
  output awl_pkg::dp_status_t       status,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [awl_pkg::ADC_W-1:0] mean_out,
  output logic [awl_pkg::MM_W-1:0]  dist_out,
  output logic                      valid_out
);
  import awl_pkg::*;

  localparam logic signed [VAL_W-1:0] MM_MAX_V = VAL_W'(MM_MAX);

  // window storage and sum
  logic [ADC_W-1:0] ring [WINDOW];
  logic [IDX_W-1:0] wpos;
  logic [IDX_W-1:0] idx;
  logic [SUM_W-1:0] acc;

  // mean and segment
  logic [ADC_W-1:0] mean;
  logic [ADC_W-1:0] mean_calc;
  logic [1:0]       seg_lo;
  logic [1:0]       seg_hi;
  logic [1:0]       seg_calc;
  logic             hit;
  logic             hit_calc;
  logic             desc;
  logic             seg_ok;

  // interpolation
  logic [ADC_W-1:0]         a_lo;
  logic [ADC_W-1:0]         a_hi;
  logic [MM_W-1:0]          d_lo;
  logic [MM_W-1:0]          d_hi;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DD_W-1:0]   dd;
  logic signed [DIFF_W-1:0] den_s;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        prod_abs;
  logic [DIFF_W-1:0]        den_abs;
  logic                     neg;
  logic [ADC_W-1:0]         den;
  logic [ADC_W-1:0]         rem;
  logic [Q_W-1:0]           sh;
  logic [DCNT_W-1:0]        dcnt;

  // radix-4 restoring step
  logic [ADC_W:0]   r1;
  logic [ADC_W:0]   r2;
  logic [ADC_W-1:0] r1s;
  logic [ADC_W-1:0] r2s;
  logic             ge1;
  logic             ge2;

  // result
  logic signed [VAL_W-1:0] qs;
  logic signed [VAL_W-1:0] val;
  logic [MM_W-1:0]         dist_sat;

  // segment breakpoints
  assign seg_hi = seg_lo + 2'd1;
  assign a_lo   = cfg.adc_pt[seg_lo];
  assign a_hi   = cfg.adc_pt[seg_hi];
  assign d_lo   = cfg.mm_pt[seg_lo];
  assign d_hi   = cfg.mm_pt[seg_hi];
  assign seg_ok = hit && (a_hi != a_lo);

  // floor mean and segment search
  assign mean_calc = ADC_W'(acc / WINDOW);
  assign desc      = cfg.adc_pt[0] > cfg.adc_pt[3];

  always_comb begin
    hit_calc = 1'b1;
    seg_calc = 2'd0;
    if (desc) begin
      if (mean_calc <= cfg.adc_pt[0] && mean_calc > cfg.adc_pt[1]) begin
        seg_calc = 2'd0;
      end else if (mean_calc <= cfg.adc_pt[1] && mean_calc > cfg.adc_pt[2]) begin
        seg_calc = 2'd1;
      end else if (mean_calc <= cfg.adc_pt[2] && mean_calc >= cfg.adc_pt[3]) begin
        seg_calc = 2'd2;
      end else begin
        hit_calc = 1'b0;
      end
    end else begin
      if (mean_calc >= cfg.adc_pt[0] && mean_calc < cfg.adc_pt[1]) begin
        seg_calc = 2'd0;
      end else if (mean_calc >= cfg.adc_pt[1] && mean_calc < cfg.adc_pt[2]) begin
        seg_calc = 2'd1;
      end else if (mean_calc >= cfg.adc_pt[2] && mean_calc <= cfg.adc_pt[3]) begin
        seg_calc = 2'd2;
      end else begin
        hit_calc = 1'b0;
      end
    end
  end

  // magnitudes for the divider
  assign prod_abs = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
  assign den_abs  = den_s[DIFF_W-1] ? DIFF_W'(-den_s) : DIFF_W'(den_s);

  // two quotient bits per step
  always_comb begin
    r1  = {rem, sh[Q_W-1]};
    ge1 = r1 >= {1'b0, den};
    r1s = ge1 ? ADC_W'(r1 - {1'b0, den}) : r1[ADC_W-1:0];
    r2  = {r1s, sh[Q_W-2]};
    ge2 = r2 >= {1'b0, den};
    r2s = ge2 ? ADC_W'(r2 - {1'b0, den}) : r2[ADC_W-1:0];
  end

  // signed quotient plus base distance, clamped
  always_comb begin
    qs  = neg ? -$signed({2'b00, sh}) : $signed({2'b00, sh});
    val = $signed({{(VAL_W-MM_W){1'b0}}, d_lo}) + qs;
    if (val < 0) begin
      dist_sat = '0;
    end else if (val > MM_MAX_V) begin
      dist_sat = MM_W'(MM_MAX);
    end else begin
      dist_sat = val[MM_W-1:0];
    end
  end

  // ring and write position
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        ring[i] <= '0;
      end
      wpos <= '0;
    end else if (ctrl.fire && ctrl.op == OP_LOAD) begin
      ring[wpos] <= sample;
      wpos <= (wpos == IDX_W'(WINDOW - 1)) ? '0 : wpos + 1'b1;
    end
  end

  // arithmetic datapath
  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      case (ctrl.op)
        OP_LOAD: begin
          acc <= '0;
          idx <= '0;
        end
        OP_ACC: begin
          acc <= acc + SUM_W'(ring[idx]);
          idx <= idx + 1'b1;
        end
        OP_MEAN: begin
          mean   <= mean_calc;
          seg_lo <= seg_calc;
          hit    <= hit_calc;
        end
        OP_SETUP: begin
          diff  <= $signed({1'b0, mean}) - $signed({1'b0, a_lo});
          dd    <= $signed({1'b0, d_hi}) - $signed({1'b0, d_lo});
          den_s <= $signed({1'b0, a_hi}) - $signed({1'b0, a_lo});
        end
        OP_MUL: begin
          prod <= diff * dd;
        end
        OP_DIVINIT: begin
          neg  <= prod[PROD_W-1] ^ den_s[DIFF_W-1];
          den  <= den_abs[ADC_W-1:0];
          rem  <= prod_abs[PROD_W-2:Q_W];
          sh   <= prod_abs[Q_W-1:0];
          dcnt <= '0;
        end
        OP_DIV: begin
          rem  <= r2s;
          sh   <= {sh[Q_W-3:0], ge1, ge2};
          dcnt <= dcnt + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.fire && ctrl.op == OP_FINISH) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire && ctrl.op == OP_FINISH) begin
      mean_out  <= mean;
      dist_out  <= seg_ok ? dist_sat : '0;
      valid_out <= seg_ok;
    end
  end

  // status back to the sequencer
  assign status.sum_more = (idx != IDX_W'(WINDOW - 1));
  assign status.div_more = (dcnt != DCNT_W'(DIV_STEPS - 1));
  assign status.seg_skip = !seg_ok;
  assign status.out_busy = out_valid && !out_ready;

  `ASSERT_IMPLIES(a_rem_below_den, clk, rst, ctrl.fire && ctrl.op == OP_DIV, rem < den, "partial remainder not below divisor")
  `ASSERT_IMPLIES(a_invalid_is_zero, clk, rst, out_valid && !valid_out, dist_out == '0, "invalid result with nonzero distance")

endmodule

### hw/rtl/adc_window_average_linearizer.sv
// a sample passes the eight-step window sum, mean and segment search, setup,
// multiply, divider init and the seven radix-4 divide steps of the shared datapath,
// or branches from setup straight to finish when the mean is outside all segments
// or the segment is degenerate; a new sample is taken only after the finish step
// reset: synchronous, clears the window to zero and loads default breakpoints
module adc_window_average_linearizer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [awl_pkg::S_DATA_W-1:0]   s_tdata,   // [9:0] sample
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [awl_pkg::M_DATA_W-1:0]   m_tdata,   // [9:0] mean_sample, [22:10] distance_mm
  output logic                           m_tuser,   // [0] valid_res
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [awl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [awl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import awl_pkg::*;

  cfg_t             cfg;
  dp_ctrl_t         ctrl;
  dp_status_t       status;
  logic [ADC_W-1:0] mean_out;
  logic [MM_W-1:0]  dist_out;

  // configuration registers
  awl_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // microcode sequencer
  awl_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .ctrl     (ctrl)
  );

  // datapath
  awl_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cfg       (cfg),
    .sample    (s_tdata[ADC_W-1:0]),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .mean_out  (mean_out),
    .dist_out  (dist_out),
    .valid_out (m_tuser)
  );

  // pack result fields
  assign m_tdata = {{(M_DATA_W - ADC_W - MM_W){1'b0}}, dist_out, mean_out};

endmodule
